// ===== design/a2bc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2bc_pkg
// Shared types, constants and index helpers for the Argon2 compression core.
// ----------------------------------------------------------------------------
package a2bc_pkg;

  localparam int WORD_W    = 64;
  localparam int PAIR_W    = 2 * WORD_W;
  localparam int PAIRS     = 64;
  localparam int PAIR_AW   = $clog2(PAIRS);
  localparam int LANES     = 4;
  localparam int STATE_N   = 16;

  typedef struct packed {
    logic [WORD_W-1:0] x_even;
    logic [WORD_W-1:0] x_odd;
    logic [WORD_W-1:0] y_even;
    logic [WORD_W-1:0] y_odd;
    logic              block_end;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] z_even;
    logic [WORD_W-1:0] z_odd;
    logic              final_pair;
  } out_item_t;

  // Control from the sequencer to every quarter-round lane
  typedef struct packed {
    logic       mul_en;
    logic [1:0] sub;
  } lane_ctrl_t;

  typedef struct packed {
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] rot;
  } lane_out_t;

  // Operand roles inside a quarter round
  localparam logic [1:0] ROLE_A = 2'd0;
  localparam logic [1:0] ROLE_B = 2'd1;
  localparam logic [1:0] ROLE_C = 2'd2;
  localparam logic [1:0] ROLE_D = 2'd3;

  // State word index of a role for a lane; diagonal half rotates the lane
  function automatic logic [3:0] qr_idx(input logic diag, input logic [1:0] lane,
                                        input logic [1:0] role);
    logic [1:0] col;
    col = diag ? 2'(lane + role) : lane;
    return {role, col};
  endfunction

endpackage

// ===== design/argon2_block_compression_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argon2_block_compression_core
// Argon2 compression G(X, Y) with four parallel BlaMka quarter-round lanes.
// ----------------------------------------------------------------------------
// One block takes 64 input transactions, one per cycle while in_stall is low,
// each storing one pair of R = X xor Y. The transaction marked block_end
// starts compression: for each of the 8 rows and then the 8 columns, 8 pairs
// are read from RAM into a 16-word register file, four lanes run the column
// and diagonal quarter rounds side by side (a multiply state and then an add
// state per step), and the words are written back. Each lane has one
// multiplier. The 64 result transactions then leave one at a time, each
// through a RAM read, a capture and a handshake, and the block reads another
// pair only after a result is taken. Input stall stays high during reset
// and from block_end until the last result is taken.
// ----------------------------------------------------------------------------
module argon2_block_compression_core
  import a2bc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LOAD     = 3'd1;
  localparam logic [2:0] S_MUL      = 3'd2;
  localparam logic [2:0] S_ADD      = 3'd3;
  localparam logic [2:0] S_STORE    = 3'd4;
  localparam logic [2:0] S_OUT_RD   = 3'd5;
  localparam logic [2:0] S_OUT_CAP  = 3'd6;
  localparam logic [2:0] S_OUT_HOLD = 3'd7;

  logic [2:0]         state;
  logic [PAIR_AW-1:0] load_count;
  logic               pass;      // 0 rows, 1 columns
  logic [2:0]         grp;
  logic [3:0]         cnt;
  logic               diag;
  logic [1:0]         sub;
  logic [PAIR_AW-1:0] out_idx;
  logic [WORD_W-1:0]  v [STATE_N];

  logic in_fire;
  logic out_fire;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = rst || (state != S_IDLE);

  // Row pairs are contiguous, column pairs stride by 8
  logic [PAIR_AW-1:0] grp_addr;
  assign grp_addr = pass ? {cnt[2:0], grp} : {grp, cnt[2:0]};

  // R storage
  logic               xr_we;
  logic [PAIR_AW-1:0] xr_raddr;
  logic [PAIR_W-1:0]  xr_rdata;
  assign xr_we    = in_fire;
  assign xr_raddr = (state == S_LOAD) ? grp_addr : out_idx;

  a2bc_ram #(.WIDTH(PAIR_W), .DEPTH(PAIRS)) u_xor_ram (
    .clk     (clk),
    .wr_en   (xr_we),
    .wr_addr (load_count),
    .wr_data ({in_data.x_odd ^ in_data.y_odd, in_data.x_even ^ in_data.y_even}),
    .rd_addr (xr_raddr),
    .rd_data (xr_rdata)
  );

  // Permutation scratch
  logic               wk_we;
  logic [PAIR_AW-1:0] wk_raddr;
  logic [PAIR_W-1:0]  wk_rdata;
  assign wk_we    = (state == S_STORE);
  assign wk_raddr = (state == S_LOAD) ? grp_addr : out_idx;

  a2bc_ram #(.WIDTH(PAIR_W), .DEPTH(PAIRS)) u_work_ram (
    .clk     (clk),
    .wr_en   (wk_we),
    .wr_addr (grp_addr),
    .wr_data ({v[{cnt[2:0], 1'b1}], v[{cnt[2:0], 1'b0}]}),
    .rd_addr (wk_raddr),
    .rd_data (wk_rdata)
  );

  // Lanes
  lane_ctrl_t lane_ctrl;
  lane_out_t  lane_res [LANES];
  assign lane_ctrl.mul_en = (state == S_MUL);
  assign lane_ctrl.sub    = sub;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    a2bc_lane u_lane (
      .clk  (clk),
      .ctrl (lane_ctrl),
      .a    (v[qr_idx(diag, 2'(i), ROLE_A)]),
      .b    (v[qr_idx(diag, 2'(i), ROLE_B)]),
      .c    (v[qr_idx(diag, 2'(i), ROLE_C)]),
      .d    (v[qr_idx(diag, 2'(i), ROLE_D)]),
      .res  (lane_res[i])
    );
  end

  // Merge: load from RAM, or write lane results back into the state words
  logic [PAIR_W-1:0] load_data;
  logic [2:0]        load_slot;
  assign load_data = pass ? wk_rdata : xr_rdata;
  assign load_slot = 3'(cnt - 4'd1);

  always_ff @(posedge clk) begin
    if (state == S_LOAD && cnt != 4'd0) begin
      v[{load_slot, 1'b0}] <= load_data[WORD_W-1:0];
      v[{load_slot, 1'b1}] <= load_data[PAIR_W-1:WORD_W];
    end else if (state == S_ADD) begin
      for (int i = 0; i < LANES; i++) begin
        if (sub[0]) begin
          v[qr_idx(diag, 2'(i), ROLE_C)] <= lane_res[i].sum;
          v[qr_idx(diag, 2'(i), ROLE_B)] <= lane_res[i].rot;
        end else begin
          v[qr_idx(diag, 2'(i), ROLE_A)] <= lane_res[i].sum;
          v[qr_idx(diag, 2'(i), ROLE_D)] <= lane_res[i].rot;
        end
      end
    end
  end

  // Output payload: Z = P(R) xor R
  always_ff @(posedge clk) begin
    if (state == S_OUT_CAP) begin
      out_data.z_even     <= wk_rdata[WORD_W-1:0] ^ xr_rdata[WORD_W-1:0];
      out_data.z_odd      <= wk_rdata[PAIR_W-1:WORD_W] ^ xr_rdata[PAIR_W-1:WORD_W];
      out_data.final_pair <= (out_idx == PAIR_AW'(PAIRS - 1));
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      load_count <= '0;
      pass       <= 1'b0;
      grp        <= '0;
      cnt        <= '0;
      diag       <= 1'b0;
      sub        <= '0;
      out_idx    <= '0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_data.block_end) begin
              load_count <= '0;
              state      <= S_LOAD;
              pass       <= 1'b0;
              grp        <= '0;
              cnt        <= '0;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        S_LOAD: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd8) begin
            state <= S_MUL;
            diag  <= 1'b0;
            sub   <= '0;
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          sub   <= sub + 2'd1;
          state <= S_MUL;
          if (sub == 2'd3) begin
            diag <= 1'b1;
            if (diag) begin
              state <= S_STORE;
              cnt   <= '0;
            end
          end
        end
        S_STORE: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd7) begin
            cnt   <= '0;
            grp   <= grp + 3'd1;
            state <= S_LOAD;
            if (grp == 3'd7) begin
              if (pass) begin
                state   <= S_OUT_RD;
                out_idx <= '0;
              end else begin
                pass <= 1'b1;
              end
            end
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_CAP;
        end
        S_OUT_CAP: begin
          out_valid <= 1'b1;
          state     <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (out_fire) begin
            out_valid <= 1'b0;
            out_idx   <= out_idx + 1'b1;
            state     <= (out_idx == PAIR_AW'(PAIRS - 1)) ? S_IDLE : S_OUT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_valid_in_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT_HOLD)
    else $error("result valid outside hold state");

  a_end_starts_load: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.block_end |=> state == S_LOAD && cnt == 4'd0)
    else $error("block end did not start compression");

  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_fire && out_data.final_pair |=> state == S_IDLE && !out_valid)
    else $error("final result did not return to idle");

  a_no_input_in_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

endmodule

// ===== design/a2bc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2bc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module a2bc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/a2bc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2bc_lane
// One BlaMka quarter-round lane: registered 32x32 product, then add and rotate.
// ----------------------------------------------------------------------------
module a2bc_lane
  import a2bc_pkg::*;
(
  input  logic              clk,
  input  lane_ctrl_t        ctrl,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  input  logic [WORD_W-1:0] c,
  input  logic [WORD_W-1:0] d,
  output lane_out_t         res
);

  logic [WORD_W-1:0] op_x;
  logic [WORD_W-1:0] op_y;
  logic [WORD_W-1:0] op_t;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] mix;

  // Odd steps work on (c, d) and rotate b; even steps on (a, b) and rotate d
  assign op_x = ctrl.sub[0] ? c : a;
  assign op_y = ctrl.sub[0] ? d : b;
  assign op_t = ctrl.sub[0] ? b : d;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= {32'd0, op_x[31:0]} * {32'd0, op_y[31:0]};
    end
  end

  assign sum = op_x + op_y + {prod[WORD_W-2:0], 1'b0};
  assign mix = op_t ^ sum;

  always_comb begin
    res.sum = sum;
    unique case (ctrl.sub)
      2'd0:    res.rot = {mix[31:0], mix[63:32]};
      2'd1:    res.rot = {mix[23:0], mix[63:24]};
      2'd2:    res.rot = {mix[15:0], mix[63:16]};
      default: res.rot = {mix[62:0], mix[63]};
    endcase
  end

endmodule
